/* rtl/core/bhq_pkg.sv */
// ----------------------------------------------------------------------------
// bhq_pkg
// Shared types, codes and default sizes for the binary max-heap queue core.
// ----------------------------------------------------------------------------
package bhq_pkg;

  // default sizes
  localparam int unsigned CAPACITY_DEF  = 64;
  localparam int unsigned PRIO_BITS_DEF = 32;

  // fixed port widths
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned PORT_PRIO_W = 32;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned ENT_W       = 7;
  localparam int unsigned STAT_W      = 2;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT  = 2'd0,
    FN_EXTRACT = 2'd1,
    FN_CHANGE  = 2'd2,
    FN_REMOVE  = 2'd3
  } func_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_SLOT  = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_UP,
    S_UP_CMP,
    S_CHG_RD,
    S_CHG_CMP,
    S_DN,
    S_DN_L,
    S_DN_R,
    S_RM_RD,
    S_RM_CAP,
    S_RM_SH,
    S_RM_WR,
    S_LAST_RD,
    S_LAST_CAP,
    S_DONE
  } state_t;

  // heap memory port controls
  typedef struct packed {
    logic we;
    logic re_a;
    logic re_b;
  } ram_ctl_t;

  // result strobe from the sequencer
  typedef struct packed {
    logic    valid;
    status_t status;
  } res_ctl_t;

endpackage

/* rtl/core/binary_max_heap_queue_core.sv */
// ----------------------------------------------------------------------------
// binary_max_heap_queue_core
// Binary max-heap priority queue: insert, extract max, change priority and
// remove slot, each answered by one result transaction.
//
// Usage: a request transaction on in_* carries an operation, a priority and
// a slot; one result transaction on out_* returns a priority, the entry count
// and a status. One request is in flight at a time; in_ready is high only
// while the sequencer is idle.
// Sift speed is set by the single compare unit and the one heap memory
// write port: a step up costs one read and one compare-and-write; a step
// down costs one read of both children, one compare and one compare-and-write.
// The next request is accepted the cycle after the result is registered.
// A stalled receiver holds the result in the output register; the sequencer
// then waits with a finished result until that register frees up.
// Reset empties the heap at once (entry count to zero); no clearing pass.
// ----------------------------------------------------------------------------
module binary_max_heap_queue_core #(
  parameter int unsigned CAPACITY  = bhq_pkg::CAPACITY_DEF,
  parameter int unsigned PRIO_BITS = bhq_pkg::PRIO_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [bhq_pkg::FUNC_W-1:0]            in_func,
  input  logic signed [bhq_pkg::PORT_PRIO_W-1:0] in_prio_in,
  input  logic [bhq_pkg::SLOT_W-1:0]            in_slot,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [bhq_pkg::PORT_PRIO_W-1:0] out_prio_out,
  output logic [bhq_pkg::ENT_W-1:0]             out_entries,
  output logic [bhq_pkg::STAT_W-1:0]            out_status
);
  import bhq_pkg::*;

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic signed [PRIO_BITS-1:0] prio_ext;
  logic                        out_free;
  res_ctl_t                    res_ctl;
  logic signed [PRIO_BITS-1:0] res_prio;
  logic [CW-1:0]               res_cnt;
  ram_ctl_t                    ram_ctl;
  logic [IW-1:0]               waddr;
  logic [PRIO_BITS-1:0]        wdata;
  logic [IW-1:0]               raddr_a;
  logic [IW-1:0]               raddr_b;
  logic [PRIO_BITS-1:0]        rdata_a;
  logic [PRIO_BITS-1:0]        rdata_b;
  logic signed [PRIO_BITS-1:0] cmp_lhs;
  logic signed [PRIO_BITS-1:0] cmp_rhs;
  logic                        cmp_gt;

  logic                        out_valid_r, out_valid_nxt;
  logic signed [PORT_PRIO_W-1:0] out_prio_r;
  logic [ENT_W-1:0]            out_ent_r;
  logic [STAT_W-1:0]           out_stat_r;

  // priority taken from the low PRIO_BITS bits as a signed value
  assign prio_ext = PRIO_BITS'(in_prio_in);

  bhq_seq #(
    .CAPACITY  (CAPACITY),
    .PRIO_BITS (PRIO_BITS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_func  (in_func),
    .in_prio  (prio_ext),
    .in_slot  (in_slot),
    .out_free (out_free),
    .res_ctl  (res_ctl),
    .res_prio (res_prio),
    .res_cnt  (res_cnt),
    .ram_ctl  (ram_ctl),
    .waddr    (waddr),
    .wdata    (wdata),
    .raddr_a  (raddr_a),
    .raddr_b  (raddr_b),
    .rdata_a  (rdata_a),
    .rdata_b  (rdata_b),
    .cmp_lhs  (cmp_lhs),
    .cmp_rhs  (cmp_rhs),
    .cmp_gt   (cmp_gt)
  );

  bhq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (PRIO_BITS)
  ) u_ram (
    .clk     (clk),
    .ctl     (ram_ctl),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  bhq_cmp #(
    .PRIO_BITS (PRIO_BITS)
  ) u_cmp (
    .lhs (cmp_lhs),
    .rhs (cmp_rhs),
    .gt  (cmp_gt)
  );

  // output register parts the sequencer from the receiver
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ctl.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ctl.valid) begin
      out_prio_r <= PORT_PRIO_W'(res_prio);
      out_ent_r  <= ENT_W'(res_cnt);
      out_stat_r <= res_ctl.status;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_prio_out = out_prio_r;
  assign out_entries  = out_ent_r;
  assign out_status   = out_stat_r;

`ifndef SYNTH
  // one request at a time: busy right after a request transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while a previous one is in flight");

  // the sequencer never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_ctl.valid |-> (!out_valid_r || out_ready))
    else $error("result loaded into a busy output register");

  // an empty report carries a zero value and no entries
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_entries == '0 && out_prio_out == '0)
    else $error("empty status with nonzero value or count");

  // a full report means the heap is at capacity
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_entries == ENT_W'(CAPACITY))
    else $error("full status below capacity");
`endif

endmodule

/* rtl/core/bhq_ram.sv */
// ----------------------------------------------------------------------------
// bhq_ram
// Heap storage: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module bhq_ram #(
  parameter int unsigned DEPTH = bhq_pkg::CAPACITY_DEF,
  parameter int unsigned WIDTH = bhq_pkg::PRIO_BITS_DEF
) (
  input  logic                                        clk,
  input  bhq_pkg::ram_ctl_t                           ctl,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                            rdata_a,
  output logic [WIDTH-1:0]                            rdata_b
);
  import bhq_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, data held while not enabled
  always_ff @(posedge clk) begin
    if (ctl.re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (ctl.re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* rtl/core/bhq_cmp.sv */
// ----------------------------------------------------------------------------
// bhq_cmp
// Shared signed priority comparator used by every sift step.
// ----------------------------------------------------------------------------
module bhq_cmp #(
  parameter int unsigned PRIO_BITS = bhq_pkg::PRIO_BITS_DEF
) (
  input  logic signed [PRIO_BITS-1:0] lhs,
  input  logic signed [PRIO_BITS-1:0] rhs,
  output logic                        gt
);
  import bhq_pkg::*;

  // strict greater-than on two's complement priorities
  assign gt = (lhs > rhs);

endmodule

/* rtl/core/bhq_seq.sv */
// ----------------------------------------------------------------------------
// bhq_seq
// Operation sequencer: walks the heap one level at a time through the
// shared comparator and the heap memory, keeping the moving entry in a
// register and writing each displaced entry into the hole.
// ----------------------------------------------------------------------------
module bhq_seq #(
  parameter int unsigned CAPACITY  = bhq_pkg::CAPACITY_DEF,
  parameter int unsigned PRIO_BITS = bhq_pkg::PRIO_BITS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  // request side
  input  logic                                              in_valid,
  output logic                                              in_ready,
  input  logic [bhq_pkg::FUNC_W-1:0]                        in_func,
  input  logic signed [PRIO_BITS-1:0]                       in_prio,
  input  logic [bhq_pkg::SLOT_W-1:0]                        in_slot,
  // result side
  input  logic                                              out_free,
  output bhq_pkg::res_ctl_t                                 res_ctl,
  output logic signed [PRIO_BITS-1:0]                       res_prio,
  output logic [$clog2(CAPACITY+1)-1:0]                     res_cnt,
  // heap memory
  output bhq_pkg::ram_ctl_t                                 ram_ctl,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] waddr,
  output logic [PRIO_BITS-1:0]                              wdata,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] raddr_a,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] raddr_b,
  input  logic [PRIO_BITS-1:0]                              rdata_a,
  input  logic [PRIO_BITS-1:0]                              rdata_b,
  // shared comparator
  output logic signed [PRIO_BITS-1:0]                       cmp_lhs,
  output logic signed [PRIO_BITS-1:0]                       cmp_rhs,
  input  logic                                              cmp_gt
);
  import bhq_pkg::*;

  localparam int unsigned IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned CHW = IW + 2;
  localparam int unsigned SW  = (CW > SLOT_W) ? CW : SLOT_W;

  state_t                        state_r, state_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [IW-1:0]                 i_r, i_nxt;
  logic signed [PRIO_BITS-1:0]   cur_r, cur_nxt;
  logic signed [PRIO_BITS-1:0]   res_r, res_nxt;
  logic signed [PRIO_BITS-1:0]   best_r, best_nxt;
  logic                          best_l_r, best_l_nxt;
  logic                          take_r, take_nxt;
  status_t                       status_r, status_nxt;
  logic signed [PRIO_BITS-1:0]   root_r, root_nxt;

  logic [IW-1:0]                 i_dec;
  logic [IW-1:0]                 par_idx;
  logic [CHW-1:0]                lc_w;
  logic [CHW-1:0]                rc_w;
  logic                          lv;
  logic                          rv;
  logic                          full;
  logic                          empty;
  logic                          slot_big;
  func_t                         in_fn;

  // index arithmetic around the current hole
  assign i_dec    = i_r - IW'(1);
  assign par_idx  = i_dec >> 1;
  assign lc_w     = CHW'({i_r, 1'b1});
  assign rc_w     = lc_w + CHW'(1);
  assign lv       = (lc_w < CHW'(cnt_r));
  assign rv       = (rc_w < CHW'(cnt_r));
  assign full     = (cnt_r == CW'(CAPACITY));
  assign empty    = (cnt_r == '0);
  assign slot_big = (SW'(in_slot) >= SW'(cnt_r));
  assign in_fn    = func_t'(in_func);

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    cur_r    <= cur_nxt;
    res_r    <= res_nxt;
    best_r   <= best_nxt;
    best_l_r <= best_l_nxt;
    take_r   <= take_nxt;
    status_r <= status_nxt;
    root_r   <= root_nxt;
  end

  // next state and memory / comparator control
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    i_nxt       = i_r;
    cur_nxt     = cur_r;
    res_nxt     = res_r;
    best_nxt    = best_r;
    best_l_nxt  = best_l_r;
    take_nxt    = take_r;
    status_nxt  = status_r;
    in_ready    = 1'b0;
    res_ctl     = '{valid: 1'b0, status: status_r};
    ram_ctl     = '0;
    waddr       = i_r;
    wdata       = cur_r;
    raddr_a     = i_r;
    raddr_b     = rc_w[IW-1:0];
    cmp_lhs     = cur_r;
    cmp_rhs     = rdata_a;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cur_nxt    = in_prio;
          take_nxt   = 1'b0;
          status_nxt = ST_OK;
          priority if (in_fn == FN_INSERT && full) begin
            status_nxt = ST_FULL;
            state_nxt  = S_DONE;
          end else if (in_fn == FN_INSERT) begin
            i_nxt     = IW'(cnt_r);
            cnt_nxt   = cnt_r + CW'(1);
            state_nxt = S_UP;
          end else if (empty) begin
            status_nxt = ST_EMPTY;
            state_nxt  = S_DONE;
          end else if (in_fn == FN_EXTRACT) begin
            res_nxt   = root_r;
            take_nxt  = 1'b1;
            cnt_nxt   = cnt_r - CW'(1);
            state_nxt = S_LAST_RD;
          end else if (slot_big) begin
            status_nxt = ST_SLOT;
            state_nxt  = S_DONE;
          end else if (in_fn == FN_CHANGE) begin
            i_nxt     = IW'(in_slot);
            state_nxt = S_CHG_RD;
          end else begin
            i_nxt     = IW'(in_slot);
            take_nxt  = 1'b1;
            state_nxt = S_RM_RD;
          end
        end
      end

      // sift up: fetch the parent of the hole, or write the entry at the root
      S_UP: begin
        if (i_r == '0) begin
          ram_ctl.we = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          ram_ctl.re_a = 1'b1;
          raddr_a      = par_idx;
          state_nxt    = S_UP_CMP;
        end
      end

      // sift up: parent drops into the hole or the entry settles
      S_UP_CMP: begin
        ram_ctl.we = 1'b1;
        if (cmp_gt) begin
          wdata     = rdata_a;
          i_nxt     = par_idx;
          state_nxt = S_UP;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_CHG_RD: begin
        ram_ctl.re_a = 1'b1;
        state_nxt    = S_CHG_CMP;
      end

      // new priority against the old one picks the direction
      S_CHG_CMP: begin
        state_nxt = cmp_gt ? S_UP : S_DN;
      end

      // sift down: fetch both children
      S_DN: begin
        ram_ctl.re_a = 1'b1;
        ram_ctl.re_b = 1'b1;
        raddr_a      = lc_w[IW-1:0];
        state_nxt    = S_DN_L;
      end

      // left child against the moving entry
      S_DN_L: begin
        cmp_lhs = rdata_a;
        cmp_rhs = cur_r;
        if (lv && cmp_gt) begin
          best_nxt   = rdata_a;
          best_l_nxt = 1'b1;
        end else begin
          best_nxt   = cur_r;
          best_l_nxt = 1'b0;
        end
        state_nxt = S_DN_R;
      end

      // right child against the best so far, then fill the hole
      S_DN_R: begin
        cmp_lhs    = rdata_b;
        cmp_rhs    = best_r;
        ram_ctl.we = 1'b1;
        priority if (rv && cmp_gt) begin
          wdata     = rdata_b;
          i_nxt     = rc_w[IW-1:0];
          state_nxt = S_DN;
        end else if (best_l_r) begin
          wdata     = best_r;
          i_nxt     = lc_w[IW-1:0];
          state_nxt = S_DN;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_RM_RD: begin
        ram_ctl.re_a = 1'b1;
        state_nxt    = S_RM_CAP;
      end

      S_RM_CAP: begin
        res_nxt   = rdata_a;
        state_nxt = S_RM_SH;
      end

      // remove: each ancestor drops one level toward the slot
      S_RM_SH: begin
        if (i_r == '0) begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_LAST_RD;
        end else begin
          ram_ctl.re_a = 1'b1;
          raddr_a      = par_idx;
          state_nxt    = S_RM_WR;
        end
      end

      S_RM_WR: begin
        ram_ctl.we = 1'b1;
        wdata      = rdata_a;
        i_nxt      = par_idx;
        state_nxt  = S_RM_SH;
      end

      // fetch the last entry to refill the root
      S_LAST_RD: begin
        if (empty) begin
          state_nxt = S_DONE;
        end else begin
          ram_ctl.re_a = 1'b1;
          raddr_a      = IW'(cnt_r);
          state_nxt    = S_LAST_CAP;
        end
      end

      S_LAST_CAP: begin
        cur_nxt   = rdata_a;
        i_nxt     = '0;
        state_nxt = S_DN;
      end

      // hand the result over once the output register is free
      S_DONE: begin
        if (out_free) begin
          res_ctl.valid = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // mirror of heap slot zero
  always_comb begin
    root_nxt = root_r;
    if (ram_ctl.we && waddr == '0) begin
      root_nxt = wdata;
    end
  end

  // result value: taken entry, or the root after the operation
  assign res_prio = take_r ? res_r : (empty ? '0 : root_r);
  assign res_cnt  = cnt_r;

endmodule
